FILE: sv/sgd_pkg.sv
// Shared types and constants of the swipe gesture detector.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sgd_pkg;

    // Window sums are 12 bits wide; a full window of 15 pixels cannot wrap them.
    localparam int SUM_W = 12;

    // Window geometry in rows and columns of the frame.
    localparam int WIN_ROW_FIRST   = 5;
    localparam int WIN_ROW_LAST    = 9;
    localparam int LEFT_COLS       = 3;
    localparam int RIGHT_COL_FIRST = 7;
    localparam int RIGHT_COL_LAST  = 9;

    // Depth of the small queues between the parts and on the result side.
    localparam int FIFO_DEPTH = 2;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_THRESH_HIGH  = 2'd0;
    localparam logic [1:0] CFG_THRESH_LOW   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT      = 2'd2;

    // Register values after reset.
    localparam logic [7:0]  THRESH_HIGH_RST = 8'd200;
    localparam logic [7:0]  THRESH_LOW_RST  = 8'd50;
    localparam logic [15:0] TIMEOUT_RST     = 16'd750;

    // Input item kinds.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Swipe codes of a result.
    localparam logic [1:0] SWIPE_NONE = 2'd0;
    localparam logic [1:0] SWIPE_L2R  = 2'd1;
    localparam logic [1:0] SWIPE_R2L  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_TIMED_OUT = 3'd1,
        ST_L1        = 3'd2,
        ST_L2        = 3'd3,
        ST_R1        = 3'd4,
        ST_R2        = 3'd5
    } gesture_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel_value;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic [1:0] swipe;
        logic       frame_done;
    } out_item_t;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        logic is_tick;
        logic frame_done;
        logic both_high;
        logic low_left;
        logic low_right;
    } action_t;

    // Status of the gesture machine seen by the top level.
    typedef struct packed {
        gesture_state_t state;
        logic           timer_running;
    } back_status_t;

endpackage

`default_nettype wire

FILE: sv/swipe_gesture_detector_unit.sv
// Top level of the swipe gesture detector: configuration registers, front
// and back parts and the queues between them. Depends on sgd_pkg, sgd_fifo,
// sgd_front and sgd_back.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one item per clock cycle while its request queue is not
// full, a pixel or a timer tick, and gives exactly one result per item in
// the same order. An accepted item waits in the request queue until the back
// part takes it; its result then waits in the result queue until popped. The
// rate of one item per cycle is set by the front part, which sums and
// classifies a pixel combinationally, and by the back part, which applies a
// frame's events to the gesture machine combinationally. Two-entry queues sit
// between the front and back parts and on the result side, so a stalled
// reader holds back the input only once both queues are full. Configuration
// registers may be written at any time the block holds no unfinished request.

module swipe_gesture_detector_unit
    import sgd_pkg::*;
#(
    parameter int FRAME_WIDTH  = 10,
    parameter int FRAME_HEIGHT = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire in_item_t    item,
    output logic             empty,
    input  wire logic        pop,
    output out_item_t        result,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [7:0]   thresh_high_reg;
    logic [7:0]   thresh_low_reg;
    logic [15:0]  timeout_ticks_reg;

    logic         accept;
    action_t      front_act;
    action_t      mid_act;
    logic         mid_full;
    logic         mid_empty;
    logic         take;
    out_item_t    back_res;
    logic         out_full;
    back_status_t back_status;

    assign accept = push && !full;
    assign full   = mid_full;
    assign take   = !mid_empty && !out_full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_high_reg   <= THRESH_HIGH_RST;
            thresh_low_reg    <= THRESH_LOW_RST;
            timeout_ticks_reg <= TIMEOUT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_THRESH_HIGH: thresh_high_reg   <= cfg_data[7:0];
                CFG_THRESH_LOW:  thresh_low_reg    <= cfg_data[7:0];
                CFG_TIMEOUT:     timeout_ticks_reg <= cfg_data;
                default:         thresh_high_reg   <= thresh_high_reg;
            endcase
        end
    end

    // Front part: position, sums and compares.
    sgd_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .thresh_high (thresh_high_reg),
        .thresh_low  (thresh_low_reg),
        .act         (front_act)
    );

    // Queue of classified requests.
    sgd_fifo #(
        .DATA_W ($bits(action_t))
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_act),
        .rd_en   (take),
        .rd_data (mid_act),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    // Back part: gesture machine and timer.
    sgd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .act           (mid_act),
        .timeout_ticks (timeout_ticks_reg),
        .res           (back_res),
        .status        (back_status)
    );

    // Result queue.
    sgd_fifo #(
        .DATA_W ($bits(out_item_t))
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (take),
        .wr_data (back_res),
        .rd_en   (pop),
        .rd_data (result),
        .full    (out_full),
        .empty   (empty)
    );

    // The timer runs exactly while a swipe is under way.
    a_timer_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.timer_running == ((back_status.state == ST_L1) ||
                                      (back_status.state == ST_L2) ||
                                      (back_status.state == ST_R1) ||
                                      (back_status.state == ST_R2)))
        else $error("timer running flag disagrees with gesture state");

    // A reported swipe always ends a frame.
    a_swipe_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (back_res.swipe != SWIPE_NONE)) |-> back_res.frame_done)
        else $error("swipe reported without a finished frame");

    // A swipe is reported only from the second step of a sequence.
    a_swipe_from_second_step: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (back_res.swipe != SWIPE_NONE)) |->
            ((back_status.state == ST_L2) || (back_status.state == ST_R2)))
        else $error("swipe reported outside the second step of a sequence");

endmodule

`default_nettype wire

FILE: sv/sgd_fifo.sv
// Two-entry queue used between the parts of the swipe gesture detector.
// Depends on sgd_pkg for the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module sgd_fifo
    import sgd_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    output logic      [DATA_W-1:0] rd_data,
    output logic                   full,
    output logic                   empty
);

    logic [DATA_W-1:0] mem [FIFO_DEPTH];
    logic              wr_ptr_reg;
    logic              wr_ptr_next;
    logic              rd_ptr_reg;
    logic              rd_ptr_next;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              do_wr;
    logic              do_rd;

    assign full  = (count_reg == 2'(FIFO_DEPTH));
    assign empty = (count_reg == 2'd0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset; entries are read only after being written.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sgd_front.sv
// Front part of the swipe gesture detector: raster position, window sums and
// the threshold compares at the end of a frame. Depends on sgd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgd_front
    import sgd_pkg::*;
#(
    parameter int FRAME_WIDTH  = 10,
    parameter int FRAME_HEIGHT = 10
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_item_t item,
    input  wire logic [7:0] thresh_high,
    input  wire logic [7:0] thresh_low,
    output action_t       act
);

    localparam int RW = $clog2(FRAME_HEIGHT);
    localparam int CW = $clog2(FRAME_WIDTH);

    logic [RW-1:0]    row_reg;
    logic [RW-1:0]    row_next;
    logic [CW-1:0]    col_reg;
    logic [CW-1:0]    col_next;
    logic [SUM_W-1:0] left_sum_reg;
    logic [SUM_W-1:0] left_sum_next;
    logic [SUM_W-1:0] right_sum_reg;
    logic [SUM_W-1:0] right_sum_next;

    logic [RW-1:0]    row_cur;
    logic [CW-1:0]    col_cur;
    logic [SUM_W-1:0] left_base;
    logic [SUM_W-1:0] right_base;
    logic [SUM_W-1:0] pix_ext;
    logic [SUM_W-1:0] left_sum;
    logic [SUM_W-1:0] right_sum;
    logic             in_rows;
    logic             last;
    logic [SUM_W-1:0] high_one;
    logic [SUM_W-1:0] high_level;
    logic [SUM_W-1:0] low_ext;
    logic [SUM_W-1:0] low_level;

    // A frame start restarts position and sums at this pixel.
    always_comb
    begin
        row_cur    = item.frame_start ? '0 : row_reg;
        col_cur    = item.frame_start ? '0 : col_reg;
        left_base  = item.frame_start ? '0 : left_sum_reg;
        right_base = item.frame_start ? '0 : right_sum_reg;
        pix_ext    = {{(SUM_W - 8){1'b0}}, item.pixel_value};
        in_rows    = (row_cur >= RW'(WIN_ROW_FIRST)) && (row_cur <= RW'(WIN_ROW_LAST));
        left_sum   = left_base;
        right_sum  = right_base;
        if (in_rows && (col_cur < CW'(LEFT_COLS)))
        begin
            left_sum = left_base + pix_ext;
        end
        if (in_rows && (col_cur >= CW'(RIGHT_COL_FIRST)) && (col_cur <= CW'(RIGHT_COL_LAST)))
        begin
            right_sum = right_base + pix_ext;
        end
        last = (row_cur == RW'(FRAME_HEIGHT - 1)) && (col_cur == CW'(FRAME_WIDTH - 1));
    end

    // Window levels: 15 times (high + 1) and 15 times low, as shift and subtract.
    always_comb
    begin
        high_one   = {{(SUM_W - 8){1'b0}}, thresh_high} + SUM_W'(1);
        high_level = (high_one << 4) - high_one;
        low_ext    = {{(SUM_W - 8){1'b0}}, thresh_low};
        low_level  = (low_ext << 4) - low_ext;
    end

    // Classified request for the back part.
    always_comb
    begin
        act.is_tick    = (item.kind == KIND_TICK);
        act.frame_done = (item.kind == KIND_PIXEL) && last;
        act.both_high  = (left_sum >= high_level) && (right_sum >= high_level);
        act.low_left   = (left_sum < low_level);
        act.low_right  = (right_sum < low_level);
    end

    // Raster position and window sum advance.
    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        left_sum_next  = left_sum_reg;
        right_sum_next = right_sum_reg;
        if (accept && (item.kind == KIND_PIXEL))
        begin
            if (last)
            begin
                row_next       = '0;
                col_next       = '0;
                left_sum_next  = '0;
                right_sum_next = '0;
            end
            else
            begin
                left_sum_next  = left_sum;
                right_sum_next = right_sum;
                if (col_cur == CW'(FRAME_WIDTH - 1))
                begin
                    col_next = '0;
                    row_next = row_cur + RW'(1);
                end
                else
                begin
                    col_next = col_cur + CW'(1);
                    row_next = row_cur;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            left_sum_reg  <= left_sum_next;
            right_sum_reg <= right_sum_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/sgd_back.sv
// Back part of the swipe gesture detector: the gesture state machine and
// the single-shot tick timer. Depends on sgd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgd_back
    import sgd_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire action_t       act,
    input  wire logic [15:0]   timeout_ticks,
    output out_item_t          res,
    output back_status_t       status
);

    gesture_state_t state_reg;
    gesture_state_t state_next;
    logic [15:0]    timer_count_reg;
    logic [15:0]    timer_count_next;
    logic           timer_running_reg;
    logic           timer_running_next;

    assign status.state         = state_reg;
    assign status.timer_running = timer_running_reg;

    // Next state: a tick counts the timer down; frame events apply in order high, low left, low right.
    always_comb
    begin
        state_next         = state_reg;
        timer_count_next   = timer_count_reg;
        timer_running_next = timer_running_reg;
        if (take && act.is_tick)
        begin
            if (timer_running_reg)
            begin
                if (timer_count_reg <= 16'd1)
                begin
                    timer_count_next   = 16'd0;
                    timer_running_next = 1'b0;
                    unique case (state_reg) inside
                        ST_L1, ST_L2, ST_R1, ST_R2: state_next = ST_TIMED_OUT;
                        default:                    state_next = state_reg;
                    endcase
                end
                else
                begin
                    timer_count_next = timer_count_reg - 16'd1;
                end
            end
        end
        else if (take && act.frame_done)
        begin
            if (act.both_high)
            begin
                unique case (state_next) inside
                    ST_TIMED_OUT, ST_L2, ST_R2:
                    begin
                        state_next         = ST_IDLE;
                        timer_running_next = 1'b0;
                    end
                    default: state_next = state_next;
                endcase
            end
            if (act.low_left)
            begin
                unique case (state_next)
                    ST_IDLE:
                    begin
                        state_next         = ST_L1;
                        timer_count_next   = timeout_ticks;
                        timer_running_next = 1'b1;
                    end
                    ST_R1:   state_next = ST_R2;
                    default: state_next = state_next;
                endcase
            end
            if (act.low_right)
            begin
                unique case (state_next)
                    ST_IDLE:
                    begin
                        state_next         = ST_R1;
                        timer_count_next   = timeout_ticks;
                        timer_running_next = 1'b1;
                    end
                    ST_L1:   state_next = ST_L2;
                    default: state_next = state_next;
                endcase
            end
        end
    end

    // Result: a swipe is reported when a high frame completes either sequence.
    always_comb
    begin
        res.frame_done = act.frame_done && !act.is_tick;
        res.swipe      = SWIPE_NONE;
        if (res.frame_done && act.both_high)
        begin
            unique case (state_reg)
                ST_L2:   res.swipe = SWIPE_L2R;
                ST_R2:   res.swipe = SWIPE_R2L;
                default: res.swipe = SWIPE_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            timer_count_reg   <= 16'd0;
            timer_running_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            timer_count_reg   <= timer_count_next;
            timer_running_reg <= timer_running_next;
        end
    end

endmodule

`default_nettype wire
